FILE: rtl/trt_pkg.sv
// package for the three channel reload timer
// operation codes, configuration register indexes and word layouts
// no dependencies
package trt_pkg;

    // operation carried in the slave-side tuser
    localparam int OP_W = 2;
    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // channel select field width and bus value width
    localparam int CH_W  = 2;
    localparam int VAL_W = 32;

    // channels that have a start bit, an enable bit and a reload register
    localparam int NUM_RELOAD = 3;
    localparam int MASK_W     = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD_2   = 3'd4;

    // word layouts, padded to whole bytes
    localparam int IN_W  = 40;  // channel, write_value
    localparam int OUT_W = 40;  // read_value, underflow_flags, irq_pulses

endpackage

FILE: rtl/three_channel_reload_timer_core.sv
// top level of the three channel reload timer
// uses trt_pkg for operation codes, register indexes and word layouts

// Down counters (CHANNELS, three by default) of COUNT_WIDTH bits share one
// tick. Each slave-side word carries an operation: tick, load count, clear
// underflow flag or read count. On a tick every started channel among the
// first three decrements; a started channel at zero instead reloads from its
// reload register, sets its sticky underflow flag and, when its interrupt is
// enabled, sets its bit in irq_pulses for that word only. Channels above two
// have no start bit and never count; they can be loaded and read. Every word
// in gives exactly one word out, holding the addressed channel's count after
// the operation (zero for a channel number that does not exist), the sticky
// flags of channels 0 to 2 and the pulses. Rate: one word is accepted in every
// clock cycle while the skid register is empty; its result is registered in the
// output or skid register. The figure is set by the single pass of counter
// update logic between the counter registers and the output register. A
// two-entry output stage (output register plus skid register) keeps tready
// registered and lets a new word in while a finished result waits. Configuration
// is taken in any cycle and is meant to be written while the block is idle.
module three_channel_reload_timer_core #(
    parameter int CHANNELS    = 3,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave side
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [trt_pkg::IN_W-1:0]     i_s_tdata,   // channel[1:0], write_value[33:2]
    input  logic [trt_pkg::OP_W-1:0]     i_s_tuser,   // op[1:0]
    // master side
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [trt_pkg::OUT_W-1:0]    o_m_tdata,   // read_value[31:0], underflow_flags[34:32],
                                                      // irq_pulses[37:35]
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [trt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [trt_pkg::VAL_W-1:0]    i_cfg_data
);
    import trt_pkg::*;

    // channels that can count
    localparam int LOW_CH = (CHANNELS < NUM_RELOAD) ? CHANNELS : NUM_RELOAD;

    // configuration registers
    logic [MASK_W-1:0] r_start;
    logic [MASK_W-1:0] r_irq_en;
    logic [VAL_W-1:0]  r_reload [NUM_RELOAD];

    // timer state
    logic [COUNT_WIDTH-1:0] r_count [CHANNELS];
    logic [COUNT_WIDTH-1:0] n_count [CHANNELS];
    logic [CHANNELS-1:0]    r_flag;
    logic [CHANNELS-1:0]    n_flag;

    // output stage
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_word,  n_out_word;
    logic             r_skid_valid, n_skid_valid;
    logic [OUT_W-1:0] r_skid_word,  n_skid_word;
    logic             r_s_ready;

    // slave-side fields
    t_op              w_op;
    logic [CH_W-1:0]  w_ch;
    logic [VAL_W-1:0] w_wv;
    logic             w_accept;
    logic             w_take;

    // result of the current word
    logic [VAL_W-1:0]  n_read;
    logic [MASK_W-1:0] n_flags_out;
    logic [MASK_W-1:0] n_pulses;
    logic [OUT_W-1:0]  n_word;

    assign w_op     = t_op'(i_s_tuser);
    assign w_ch     = i_s_tdata[CH_W-1:0];
    assign w_wv     = i_s_tdata[CH_W +: VAL_W];
    assign w_accept = i_s_tvalid && r_s_ready;
    assign w_take   = r_out_valid && i_m_tready;

    assign o_s_tready  = r_s_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_word;
    assign o_cfg_ready = 1'b1;

    // counter update for one word
    always_comb begin
        n_count  = r_count;
        n_flag   = r_flag;
        n_pulses = '0;
        case (w_op)
            OP_TICK: begin
                for (int n = 0; n < LOW_CH; n++) begin
                    if (r_start[n]) begin
                        if (r_count[n] == '0) begin
                            // underflow: reload, flag, optional pulse
                            n_count[n] = r_reload[n][COUNT_WIDTH-1:0];
                            n_flag[n]  = 1'b1;
                            n_pulses[n] = r_irq_en[n];
                        end else begin
                            n_count[n] = r_count[n] - COUNT_WIDTH'(1);
                        end
                    end
                end
            end
            OP_LOAD: begin
                for (int n = 0; n < CHANNELS; n++) begin
                    if (int'(w_ch) == n) begin
                        n_count[n] = w_wv[COUNT_WIDTH-1:0];
                    end
                end
            end
            OP_CLEAR: begin
                for (int n = 0; n < CHANNELS; n++) begin
                    if (int'(w_ch) == n) begin
                        n_flag[n] = 1'b0;
                    end
                end
            end
            OP_READ: begin
            end
            default: begin
            end
        endcase
    end

    // result word: missing channels read as zero
    always_comb begin
        n_read      = '0;
        n_flags_out = '0;
        for (int n = 0; n < CHANNELS; n++) begin
            if (int'(w_ch) == n) begin
                n_read = VAL_W'(n_count[n]);
            end
        end
        for (int n = 0; n < LOW_CH; n++) begin
            n_flags_out[n] = n_flag[n];
        end
        n_word = {(OUT_W - VAL_W - 2*MASK_W)'(0), n_pulses, n_flags_out, n_read};
    end

    // output register plus skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_skid_valid = r_skid_valid;
        n_skid_word  = r_skid_word;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_word   = r_skid_word;
                n_skid_valid = 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_word  = n_word;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_word  = n_word;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    // control and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start      <= '0;
            r_irq_en     <= '0;
            for (int n = 0; n < NUM_RELOAD; n++) begin
                r_reload[n] <= '1;
            end
            for (int n = 0; n < CHANNELS; n++) begin
                r_count[n] <= '1;
            end
            r_flag       <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_s_ready    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_START_MASK: r_start     <= i_cfg_data[MASK_W-1:0];
                    CFG_IRQ_MASK:   r_irq_en    <= i_cfg_data[MASK_W-1:0];
                    CFG_RELOAD_0:   r_reload[0] <= i_cfg_data;
                    CFG_RELOAD_1:   r_reload[1] <= i_cfg_data;
                    CFG_RELOAD_2:   r_reload[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                r_count <= n_count;
                r_flag  <= n_flag;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            r_s_ready    <= !n_skid_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_word  <= n_out_word;
        r_skid_word <= n_skid_word;
    end

    // the skid register only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // no word is taken while the skid register holds one
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !r_s_ready)
        else $error("ready while skid register is full");

    // pulses only come from ticks
    a_pulse_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op != OP_TICK) |-> (n_pulses == '0))
        else $error("interrupt pulse on a bus operation");

    // a pulse needs a started, enabled channel whose flag is set
    a_pulse_sources: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ((n_pulses & ~(r_start & r_irq_en & n_flags_out)) == '0))
        else $error("pulse from a stopped, disabled or unflagged channel");

    // a clear of channel zero leaves its flag low in the result
    a_clear_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_CLEAR && w_ch == 2'd0) |-> !n_flags_out[0])
        else $error("flag of channel zero still set after clear");

endmodule
